// ----- rtl/pcz_pkg.sv -----
`timescale 1ns / 1ps

package pcz_pkg;

    localparam int REG_COUNT = 8;
    localparam int ZONES     = 8;
    localparam int IDX_W     = $clog2(REG_COUNT);
    localparam int PADDR_W   = IDX_W + 3;
    localparam int QUO_W     = 16;
    localparam int FIFO_DEPTH = 2;

    localparam logic [15:0] MIN_CARRIER_HZ     = 16'd500;
    localparam logic [15:0] MAX_CARRIER_HZ     = 16'd5000;
    localparam logic [15:0] DEFAULT_CARRIER_HZ = 16'd1000;

    typedef enum logic [1:0] {
        ZT_FIXED  = 2'd0,
        ZT_RAMP   = 2'd1,
        ZT_SYNC   = 2'd2,
        ZT_DITHER = 2'd3
    } zone_type_t;

    typedef logic [REG_COUNT-1:0][63:0] zone_arr_t;

    // classified transaction handed from front to back
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        zone_type_t        kind;
        logic [14:0]       f;
        logic [14:0]       fs;
        logic [14:0]       dd;
        logic signed [16:0] pdiff;
        logic [15:0]       p1;
        logic [15:0]       p2;
        logic [15:0]       rnd;
    } fifo_ent_t;

endpackage

// ----- rtl/pwm_carrier_zone_schedule.sv -----
`timescale 1ns / 1ps

// PWM carrier zone schedule. A transaction is taken on every clock edge where
// start is high and busy is low; one result per transaction is strobed by done
// for a single cycle, in order. Every result passes through the 16-stage
// pipelined divider of the ramp zones; the back end never stalls, so busy
// stays low and a new transaction may be started every cycle. The receiver
// cannot hold results off and must take each one while done is high. Zone
// registers are 64 bits at byte address 8*i on the APB port and should only
// be written while no transaction is in flight.

module pwm_carrier_zone_schedule
    import pcz_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  signed_freq,
    input  logic [15:0]         rand_word,
    output logic                done,
    output logic [15:0]         carrier_freq,
    output logic                zone_found,
    output logic [IDX_W-1:0]    zone_index,
    output logic                sync_valid,
    output logic [15:0]         pulse_count
);

    zone_arr_t        zones_reg;
    zone_arr_t        zones_next;
    logic [IDX_W-1:0] reg_idx;
    logic             push;
    fifo_ent_t        push_ent;
    logic             fifo_full;
    logic             q_vld;
    fifo_ent_t        q_ent;

    assign reg_idx = paddr[PADDR_W-1:3];
    assign pready  = 1'b1;
    assign prdata  = zones_reg[reg_idx];

    always_comb
    begin
        zones_next = zones_reg;
        if (psel && penable && pwrite && pready)
            zones_next[reg_idx] = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zones_reg <= '0;
        else
            zones_reg <= zones_next;
    end

    pcz_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .signed_freq (signed_freq),
        .rand_word   (rand_word),
        .zones       (zones_reg),
        .fifo_full   (fifo_full),
        .busy        (busy),
        .push        (push),
        .push_ent    (push_ent)
    );

    pcz_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .full     (fifo_full),
        .out_vld  (q_vld),
        .out_ent  (q_ent)
    );

    pcz_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (q_vld),
        .in_ent       (q_ent),
        .done         (done),
        .carrier_freq (carrier_freq),
        .zone_found   (zone_found),
        .zone_index   (zone_index),
        .sync_valid   (sync_valid),
        .pulse_count  (pulse_count)
    );

endmodule

// ----- rtl/pcz_front.sv -----
`timescale 1ns / 1ps

module pcz_front
    import pcz_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [15:0]        signed_freq,
    input  logic [15:0]               rand_word,
    input  zone_arr_t                 zones,
    input  logic                      fifo_full,
    output logic                      busy,
    output logic                      push,
    output fifo_ent_t                 push_ent
);

    logic              s1_vld_reg;
    logic              s1_vld_next;
    logic [14:0]       s1_f_reg;
    logic [15:0]       s1_rnd_reg;
    logic [ZONES-1:0]  s1_hit_reg;
    logic [ZONES-1:0]  hit_c;
    logic [14:0]       f_c;
    logic [15:0]       neg_c;
    logic              in_ready;
    logic              accept;
    logic [IDX_W-1:0]  sel;
    logic              found;
    logic [63:0]       z;
    logic [14:0]       z_start;
    logic [14:0]       z_end;
    logic [15:0]       z_p1;
    logic [15:0]       z_p2;

    assign in_ready = !s1_vld_reg || !fifo_full;
    assign busy     = !in_ready;
    assign accept   = start && in_ready;
    assign push     = s1_vld_reg && !fifo_full;

    // magnitude, most negative value saturates
    always_comb
    begin
        neg_c = 16'(-signed_freq);
        if (!signed_freq[15])
            f_c = signed_freq[14:0];
        else if (signed_freq == 16'sh8000)
            f_c = 15'h7fff;
        else
            f_c = neg_c[14:0];
    end

    always_comb
    begin
        for (int i = 0; i < ZONES; i++)
        begin
            hit_c[i] = (zones[i][29:15] > zones[i][14:0]) &&
                       (f_c >= zones[i][14:0]) && (f_c < zones[i][29:15]);
        end
    end

    always_comb
    begin
        s1_vld_next = in_ready ? accept : s1_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= s1_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_f_reg   <= f_c;
            s1_rnd_reg <= rand_word;
            s1_hit_reg <= hit_c;
        end
    end

    // lowest index wins
    always_comb
    begin
        sel = '0;
        for (int i = ZONES - 1; i >= 0; i--)
        begin
            if (s1_hit_reg[i])
                sel = IDX_W'(i);
        end
    end

    always_comb
    begin
        found   = |s1_hit_reg;
        z       = zones[sel];
        z_start = z[14:0];
        z_end   = z[29:15];
        z_p1    = z[47:32];
        z_p2    = z[63:48];

        push_ent.found = found;
        push_ent.idx   = found ? sel : '0;
        push_ent.kind  = found ? zone_type_t'(z[31:30]) : ZT_FIXED;
        push_ent.f     = s1_f_reg;
        push_ent.fs    = s1_f_reg - z_start;
        push_ent.dd    = z_end - z_start;
        push_ent.pdiff = $signed({1'b0, z_p1}) - $signed({1'b0, z_p2});
        push_ent.p1    = found ? z_p1 : DEFAULT_CARRIER_HZ;
        push_ent.p2    = z_p2;
        push_ent.rnd   = s1_rnd_reg;
    end

endmodule

// ----- rtl/pcz_fifo.sv -----
`timescale 1ns / 1ps

module pcz_fifo
    import pcz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  fifo_ent_t push_ent,
    output logic      full,
    output logic      out_vld,
    output fifo_ent_t out_ent
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    fifo_ent_t        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             pop;

    // back end never stalls: drain whenever something is queued
    assign out_vld = (cnt_reg != '0);
    assign pop     = out_vld;
    assign full    = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign out_ent = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_ent;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue overflow");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/pcz_back.sv -----
`timescale 1ns / 1ps

module pcz_back
    import pcz_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  fifo_ent_t           in_ent,
    output logic                done,
    output logic [15:0]         carrier_freq,
    output logic                zone_found,
    output logic [IDX_W-1:0]    zone_index,
    output logic                sync_valid,
    output logic [15:0]         pulse_count
);

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   idx;
        zone_type_t         kind;
        logic [14:0]        f;
        logic [14:0]        fs;
        logic [14:0]        dd;
        logic               neg;
        logic [15:0]        pmag;
        logic [15:0]        p1;
        logic signed [17:0] d;
        logic [15:0]        center;
        logic [15:0]        rnd;
    } b0_t;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   idx;
        zone_type_t         kind;
        logic [14:0]        dd;
        logic               neg;
        logic [15:0]        p1;
        logic [15:0]        center;
        logic signed [34:0] prod;
    } b1_t;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   idx;
        zone_type_t         kind;
        logic [14:0]        dd;
        logic               neg;
        logic [15:0]        p1;
        logic [15:0]        carrier;
        logic [14:0]        rem;
        logic [QUO_W-1:0]   low;
    } dv_t;

    function automatic logic [15:0] clamp_hz(input logic signed [34:0] v);
        logic signed [34:0] r;
        begin
            r = v;
            if (r < $signed({19'd0, MIN_CARRIER_HZ}))
                r = $signed({19'd0, MIN_CARRIER_HZ});
            if (r > $signed({19'd0, MAX_CARRIER_HZ}))
                r = $signed({19'd0, MAX_CARRIER_HZ});
            return r[15:0];
        end
    endfunction

    b0_t                b0_reg;
    b0_t                b0_next;
    logic               b0_vld_reg;
    b1_t                b1_reg;
    b1_t                b1_next;
    logic               b1_vld_reg;
    dv_t                dv_reg  [QUO_W+1];
    dv_t                dv_next [QUO_W+1];
    logic [QUO_W:0]     dv_vld_reg;

    logic               done_reg;
    logic [15:0]        carrier_freq_reg;
    logic [15:0]        carrier_freq_next;
    logic               zone_found_reg;
    logic [IDX_W-1:0]   zone_index_reg;
    logic               sync_valid_reg;
    logic               sync_valid_next;
    logic [15:0]        pulse_count_reg;

    logic [15:0]        center_c;
    logic signed [17:0] lo_c;
    logic signed [17:0] hi_c;
    logic signed [17:0] lim_c;
    logic [16:0]        pmag_c;
    logic signed [16:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [34:0] sync_v;
    logic signed [34:0] dith_v;
    logic [16:0]        ramp_c;

    // prepare: dither center and limit, ramp slope magnitude
    always_comb
    begin
        center_c = (in_ent.p1 < MIN_CARRIER_HZ) ? MIN_CARRIER_HZ : in_ent.p1;
        center_c = (center_c > MAX_CARRIER_HZ) ? MAX_CARRIER_HZ : center_c;
        lo_c     = $signed({2'b0, center_c}) - $signed({2'b0, MIN_CARRIER_HZ});
        hi_c     = $signed({2'b0, MAX_CARRIER_HZ}) - $signed({2'b0, center_c});
        lim_c    = (lo_c < hi_c) ? lo_c : hi_c;
        pmag_c   = in_ent.pdiff[16] ? 17'(-in_ent.pdiff) : 17'(in_ent.pdiff);

        b0_next.found  = in_ent.found;
        b0_next.idx    = in_ent.idx;
        b0_next.kind   = in_ent.kind;
        b0_next.f      = in_ent.f;
        b0_next.fs     = in_ent.fs;
        b0_next.dd     = in_ent.dd;
        b0_next.neg    = in_ent.pdiff[16];
        b0_next.pmag   = pmag_c[15:0];
        b0_next.p1     = in_ent.p1;
        b0_next.d      = ($signed({2'b0, in_ent.p2}) < lim_c) ? $signed({2'b0, in_ent.p2})
                                                              : lim_c;
        b0_next.center = center_c;
        b0_next.rnd    = in_ent.rnd;
    end

    // one shared multiplier
    always_comb
    begin
        case (b0_reg.kind)
            ZT_RAMP:
            begin
                mul_a = $signed({2'b0, b0_reg.fs});
                mul_b = $signed({2'b0, b0_reg.pmag});
            end
            ZT_SYNC:
            begin
                mul_a = $signed({2'b0, b0_reg.f});
                mul_b = $signed({2'b0, b0_reg.p1});
            end
            ZT_DITHER:
            begin
                mul_a = 17'($signed({~b0_reg.rnd[15], b0_reg.rnd[14:0]}));
                mul_b = b0_reg.d;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        b1_next.found  = b0_reg.found;
        b1_next.idx    = b0_reg.idx;
        b1_next.kind   = b0_reg.kind;
        b1_next.dd     = b0_reg.dd;
        b1_next.neg    = b0_reg.neg;
        b1_next.p1     = b0_reg.p1;
        b1_next.center = b0_reg.center;
        b1_next.prod   = 35'(mul_a) * 35'(mul_b);
    end

    // finish non-ramp carriers, load divider
    always_comb
    begin
        sync_v = b1_reg.prod >>> 4;
        dith_v = 35'($signed({1'b0, b1_reg.center})) + (b1_reg.prod >>> 15);

        dv_next[0].found = b1_reg.found;
        dv_next[0].idx   = b1_reg.idx;
        dv_next[0].kind  = b1_reg.kind;
        dv_next[0].dd    = b1_reg.dd;
        dv_next[0].neg   = b1_reg.neg;
        dv_next[0].p1    = b1_reg.p1;
        dv_next[0].rem   = b1_reg.prod[30:16];
        dv_next[0].low   = b1_reg.prod[15:0];
        case (b1_reg.kind)
            ZT_SYNC:   dv_next[0].carrier = clamp_hz(sync_v);
            ZT_DITHER: dv_next[0].carrier = clamp_hz(dith_v);
            default:   dv_next[0].carrier = b1_reg.p1;
        endcase
    end

    // restoring divider, one quotient bit per stage
    for (genvar s = 0; s < QUO_W; s++)
    begin : g_div
        logic [15:0] t;
        logic [15:0] t_sub;
        logic        ge;

        always_comb
        begin
            t               = {dv_reg[s].rem, dv_reg[s].low[QUO_W-1]};
            t_sub           = t - {1'b0, dv_reg[s].dd};
            ge              = (t >= {1'b0, dv_reg[s].dd});
            dv_next[s+1]     = dv_reg[s];
            dv_next[s+1].rem = ge ? t_sub[14:0] : t[14:0];
            dv_next[s+1].low = {dv_reg[s].low[QUO_W-2:0], ge};
        end
    end

    always_comb
    begin
        ramp_c = dv_reg[QUO_W].neg ? ({1'b0, dv_reg[QUO_W].p1} + {1'b0, dv_reg[QUO_W].low})
                                   : ({1'b0, dv_reg[QUO_W].p1} - {1'b0, dv_reg[QUO_W].low});
        carrier_freq_next = (dv_reg[QUO_W].kind == ZT_RAMP) ? ramp_c[15:0]
                                                            : dv_reg[QUO_W].carrier;
        sync_valid_next = dv_reg[QUO_W].found && (dv_reg[QUO_W].kind == ZT_SYNC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_vld_reg <= 1'b0;
            b1_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            b0_vld_reg <= in_vld;
            b1_vld_reg <= b0_vld_reg;
            dv_vld_reg <= {dv_vld_reg[QUO_W-1:0], b1_vld_reg};
            done_reg   <= dv_vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        for (int s = 0; s <= QUO_W; s++)
            dv_reg[s] <= dv_next[s];
        carrier_freq_reg <= carrier_freq_next;
        zone_found_reg   <= dv_reg[QUO_W].found;
        zone_index_reg   <= dv_reg[QUO_W].idx;
        sync_valid_reg   <= sync_valid_next;
        pulse_count_reg  <= sync_valid_next ? dv_reg[QUO_W].p1 : 16'd0;
    end

    assign done         = done_reg;
    assign carrier_freq = carrier_freq_reg;
    assign zone_found   = zone_found_reg;
    assign zone_index   = zone_index_reg;
    assign sync_valid   = sync_valid_reg;
    assign pulse_count  = pulse_count_reg;

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_vld_reg[QUO_W] && dv_reg[QUO_W].kind == ZT_RAMP)
            |-> (dv_reg[QUO_W].rem < dv_reg[QUO_W].dd))
        else $error("ramp divider remainder not below divisor");

    a_sync_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && sync_valid_reg) |-> zone_found_reg)
        else $error("synchronous result without a matching zone");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        b1_vld_reg |-> ##(QUO_W + 2) done_reg)
        else $error("result strobe missing after divider");

endmodule
